@@ hw/rtl/plf_pkg.sv @@
// Package for the piecewise line fit scorer: payload types, divider request
// and response types, register codes and fixed point constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plf_pkg;

  // Field widths
  localparam int unsigned XW     = 20;  // x_pos, knots: signed Q12.8
  localparam int unsigned YW     = 12;  // y_obs: unsigned Q4.8
  localparam int unsigned SLW    = 17;  // slopes: signed Q0.16
  localparam int unsigned TOLW   = 16;  // tolerance_squared: unsigned Q8.8
  localparam int unsigned SCW    = 26;  // total_score: unsigned Q10.16
  localparam int unsigned CNTW   = 11;  // points_seen
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 20;

  // Shared divider widths
  localparam int unsigned DIV_RW = 20;  // remainder and divisor
  localparam int unsigned DIV_QW = 26;  // dividend low part and quotient
  localparam int unsigned DIV_CW = 5;   // step count

  // Datapath widths
  localparam int unsigned MULW   = 29;  // multiplier operand
  localparam int unsigned PRODW  = 2 * MULW;
  localparam int unsigned MODW   = 40;  // model value, signed Q.24
  localparam int unsigned RESW   = MODW + 1;

  // Constants
  localparam logic signed [MODW-1:0] FOUR_Q24  = MODW'(64'd4 << 24);
  localparam logic signed [MODW-1:0] SEVEN_Q24 = MODW'(64'd7 << 24);
  localparam logic [SCW-1:0]         ONE_Q16   = SCW'(32'd65536);
  localparam logic [SCW-1:0]         SCORE_MAX = {SCW{1'b1}};
  localparam logic [DIV_CW-1:0]      INTERP_STEPS = DIV_CW'(26);
  localparam logic [DIV_CW-1:0]      SCORE_STEPS  = DIV_CW'(16);

  // Register reset values
  localparam logic [SLW-1:0]  SLOPE_RST = SLW'(-32'sd3277);
  localparam logic [XW-1:0]   KNOT_RST  = '0;
  localparam logic [TOLW-1:0] TOL_RST   = TOLW'(256);

  // Register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_UPPER_SLOPE = 3'd0,
    CFG_UPPER_KNOT  = 3'd1,
    CFG_LOWER_KNOT  = 3'd2,
    CFG_LOWER_SLOPE = 3'd3,
    CFG_TOL_SQ      = 3'd4
  } cfg_idx_e;

  // Channel payloads
  typedef struct packed {
    logic signed [XW-1:0] x_pos;
    logic [YW-1:0]        y_obs;
    logic                 final_point;
  } point_t;

  typedef struct packed {
    logic [SCW-1:0]  total_score;
    logic [CNTW-1:0] points_seen;
  } score_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DIV_RW-1:0] rem;    // initial partial remainder, below den
    logic [DIV_RW-1:0] den;
    logic [DIV_QW-1:0] dvd;    // dividend bits shifted in, MSB first
    logic [DIV_CW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/plf_stream_if.sv @@
// Valid/ready stream interface for the line fit scorer, payload by type.
// Used with point_t and score_t from plf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface plf_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/piecewise_line_fit_score_unit.sv @@
// Piecewise line fit scorer: sequencer, shared multiplier, accumulator.
// Outside the knots the model comes from the multiplier, between them from an
// interpolation on the shared bit-serial divider, which also computes the score.
// One point at a time; a set result waits in an output register, and a final point
// holds its last cycle while the previous result is still unaccepted.
// Async active-low reset loads register defaults, clears sum and tally; uses plf_div.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_line_fit_score_unit
  import plf_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_IW-1:0] cfg_idx_i,
  input  wire logic [CFG_DW-1:0] cfg_data_i,
  plf_stream_if.sink             point_i,
  plf_stream_if.source           score_o
);

  localparam int unsigned TW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_MUL_MODEL,
    S_MODEL,
    S_DIV_INTERP,
    S_RESID,
    S_MUL_SQ,
    S_SCORE_SETUP,
    S_DIV_SCORE,
    S_ACCUM
  } state_e;

  state_e state_q;

  // Configuration registers
  logic signed [SLW-1:0] upper_slope_q, lower_slope_q;
  logic signed [XW-1:0]  upper_knot_q, lower_knot_q;
  logic [TOLW-1:0]       tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_slope_q <= SLOPE_RST;
      upper_knot_q  <= KNOT_RST;
      lower_knot_q  <= KNOT_RST;
      lower_slope_q <= SLOPE_RST;
      tol_q         <= TOL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_UPPER_SLOPE: upper_slope_q <= cfg_data_i[SLW-1:0];
        CFG_UPPER_KNOT:  upper_knot_q  <= cfg_data_i[XW-1:0];
        CFG_LOWER_KNOT:  lower_knot_q  <= cfg_data_i[XW-1:0];
        CFG_LOWER_SLOPE: lower_slope_q <= cfg_data_i[SLW-1:0];
        CFG_TOL_SQ:      tol_q         <= cfg_data_i[TOLW-1:0];
        default: ;
      endcase
    end
  end

  // Item and datapath registers
  logic signed [XW-1:0]     x_q;
  logic [YW-1:0]            y_q;
  logic                     final_q;
  logic signed [MULW-1:0]   mula_q, mulb_q;
  logic signed [PRODW-1:0]  prod_q;
  logic signed [MODW-1:0]   base_q, model_q;
  logic [SCW-1:0]           pscore_q;
  logic [SCW-1:0]           sum_q;
  logic [TW-1:0]            tally_q;
  logic                     out_valid_q;
  score_t                   out_q;

  // Position against the knots
  logic signed [XW:0] dxa, dxc, dkn;
  logic               above, below;
  logic [XW-1:0]      span, offs;
  logic [XW+1:0]      num3;

  always_comb begin
    dxa   = {x_q[XW-1], x_q} - {upper_knot_q[XW-1], upper_knot_q};
    dxc   = {x_q[XW-1], x_q} - {lower_knot_q[XW-1], lower_knot_q};
    dkn   = {upper_knot_q[XW-1], upper_knot_q} - {lower_knot_q[XW-1], lower_knot_q};
    above = (x_q > upper_knot_q);
    below = (x_q < lower_knot_q);
    // Between the knots both differences are nonnegative and fit XW bits
    span  = dkn[XW-1:0];
    offs  = XW'(-dxa);
    num3  = {offs, 1'b0} + {2'b00, offs};
  end

  // Residual and magnitude
  logic signed [RESW-1:0] resid;
  logic [RESW-1:0]        mag;
  logic                   mag_big;

  always_comb begin
    resid   = $signed({13'b0, y_q, 16'b0}) - {model_q[MODW-1], model_q};
    mag     = resid[RESW-1] ? RESW'(-resid) : RESW'(resid);
    mag_big = (mag[RESW-1:28] != '0);
  end

  // Shared multiplier
  logic signed [PRODW-1:0] product;
  assign product = mula_q * mulb_q;

  // Squared residual scaled to Q.16 times tolerance
  logic [31:0] msq;
  logic        sq_clamp;
  assign msq      = prod_q[55:24];
  assign sq_clamp = (msq[31:16] >= tol_q);

  // Divider requests
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_comb begin
    div_req = '0;
    if (state_q == S_SETUP && !above && !below && span != '0) begin
      div_req.start = 1'b1;
      div_req.rem   = DIV_RW'(num3[XW+1:2]);
      div_req.den   = DIV_RW'(span);
      div_req.dvd   = {num3[1:0], 24'b0};
      div_req.steps = INTERP_STEPS;
    end else if (state_q == S_SCORE_SETUP && !sq_clamp) begin
      div_req.start = 1'b1;
      div_req.rem   = DIV_RW'(msq[31:16]);
      div_req.den   = DIV_RW'(tol_q);
      div_req.dvd   = {msq[15:0], 10'b0};
      div_req.steps = SCORE_STEPS;
    end
  end

  plf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Accumulate with saturation
  logic [SCW:0]  sum_ext;
  logic [SCW-1:0] sum_new;
  logic [TW-1:0]  tally_new;
  logic [TW+CNTW-1:0] tally_ext;
  logic           out_busy;

  always_comb begin
    sum_ext   = {1'b0, sum_q} + {1'b0, pscore_q};
    sum_new   = sum_ext[SCW] ? SCORE_MAX : sum_ext[SCW-1:0];
    tally_new = (tally_q < TW'(MAX_POINTS)) ? tally_q + 1'b1 : tally_q;
    tally_ext = (TW + CNTW)'(tally_new);
    out_busy  = out_valid_q && !score_o.ready;
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Result register: load on a final point, clear once taken
      if (state_q == S_ACCUM && final_q && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && score_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (point_i.valid) begin
            state_q <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (above || below) begin
            state_q <= S_MUL_MODEL;
          end else if (span == '0) begin
            state_q <= S_RESID;
          end else begin
            state_q <= S_DIV_INTERP;
          end
        end
        S_MUL_MODEL:  state_q <= S_MODEL;
        S_MODEL:      state_q <= S_RESID;
        S_DIV_INTERP: begin
          if (div_rsp.done) begin
            state_q <= S_RESID;
          end
        end
        S_RESID: begin
          if (mag_big || tol_q == '0) begin
            state_q <= S_ACCUM;
          end else begin
            state_q <= S_MUL_SQ;
          end
        end
        S_MUL_SQ: state_q <= S_SCORE_SETUP;
        S_SCORE_SETUP: begin
          state_q <= sq_clamp ? S_ACCUM : S_DIV_SCORE;
        end
        S_DIV_SCORE: begin
          if (div_rsp.done) begin
            state_q <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          if (!(final_q && out_busy)) begin
            state_q <= S_IDLE;
            if (final_q) begin
              sum_q       <= '0;
              tally_q     <= '0;
            end else begin
              sum_q   <= sum_new;
              tally_q <= tally_new;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        x_q     <= point_i.data.x_pos;
        y_q     <= point_i.data.y_obs;
        final_q <= point_i.data.final_point;
      end
      S_SETUP: begin
        if (above) begin
          mula_q <= MULW'(dxa);
          mulb_q <= MULW'(upper_slope_q);
          base_q <= FOUR_Q24;
        end else begin
          mula_q <= MULW'(dxc);
          mulb_q <= MULW'(lower_slope_q);
          base_q <= SEVEN_Q24;
        end
        // Coincident knots: model is 4
        model_q <= FOUR_Q24;
      end
      S_MUL_MODEL: prod_q <= product;
      S_MODEL:     model_q <= base_q + prod_q[MODW-1:0];
      S_DIV_INTERP: begin
        if (div_rsp.done) begin
          model_q <= FOUR_Q24 + $signed(MODW'(div_rsp.quo));
        end
      end
      S_RESID: begin
        mula_q <= $signed({1'b0, mag[27:0]});
        mulb_q <= $signed({1'b0, mag[27:0]});
        if (mag_big || mag != '0) begin
          pscore_q <= ONE_Q16;
        end else begin
          pscore_q <= '0;
        end
      end
      S_MUL_SQ:      prod_q <= product;
      S_SCORE_SETUP: pscore_q <= ONE_Q16;
      S_DIV_SCORE: begin
        if (div_rsp.done) begin
          pscore_q <= SCW'(div_rsp.quo[15:0]);
        end
      end
      S_ACCUM: begin
        if (final_q && !out_busy) begin
          out_q.total_score <= sum_new;
          out_q.points_seen <= tally_ext[CNTW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign point_i.ready = (state_q == S_IDLE);
  assign score_o.valid = out_valid_q;
  assign score_o.data  = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/plf_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on plf_pkg for request/response types and widths.
`timescale 1ns / 1ps
`default_nettype none

module plf_div
  import plf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic [DIV_RW-1:0] rem_q, rem_d;
  logic [DIV_RW-1:0] den_q, den_d;
  logic [DIV_QW-1:0] quo_q, quo_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [DIV_RW:0]   trial;
  logic [DIV_RW:0]   diff;
  logic              ge;

  // One shift-subtract step
  always_comb begin
    trial = {rem_q, quo_q[DIV_QW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
  end

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.rem;
      den_d  = req_i.den;
      quo_d  = req_i.dvd;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIV_RW-1:0] : trial[DIV_RW-1:0];
      quo_d = {quo_q[DIV_QW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire
